### hw/rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TEMP_COEFFS  = 2'd0,
        REG_PRESS_LOW    = 2'd1,
        REG_PRESS_HIGH   = 2'd2,
        REG_PRESS_LAST   = 2'd3
    } reg_idx_t;

    // divider geometry: quotient bits, dividend and divisor magnitude widths
    localparam int QW    = 35;
    localparam int REM_W = 71;
    localparam int DVS_W = 35;

    // saturation limits
    localparam int FINE_MIN  = -524288;
    localparam int FINE_MAX  = 524287;
    localparam int TEMP_MIN  = -4000;
    localparam int TEMP_MAX  = 8500;
    localparam int PRESS_MAX = 33554431;

    // per-item fields carried alongside the divider
    typedef struct packed {
        logic signed [14:0] tc;
        logic signed [19:0] fine;
        logic               dz;
        logic               neg;
        logic               ovf;
    } bsc_side_t;

endpackage

### hw/rtl/bsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_div
// Pipelined restoring divider, one quotient bit per stage, with side fields.
// ----------------------------------------------------------------------------
module bsc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [bsc_pkg::REM_W-1:0]     in_rem,
    input  logic [bsc_pkg::DVS_W-1:0]     in_dvs,
    input  bsc_pkg::bsc_side_t            in_side,
    output logic                          out_valid,
    output logic [bsc_pkg::QW-1:0]        out_quo,
    output bsc_pkg::bsc_side_t            out_side
);

    logic [bsc_pkg::QW-1:0]    vld_reg;
    logic [bsc_pkg::REM_W-1:0] rem_reg  [bsc_pkg::QW];
    logic [bsc_pkg::DVS_W-1:0] dvs_reg  [bsc_pkg::QW];
    logic [bsc_pkg::QW-1:0]    quo_reg  [bsc_pkg::QW];
    bsc_pkg::bsc_side_t        side_reg [bsc_pkg::QW];

    // valid bits shift with the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[bsc_pkg::QW-2:0], in_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < bsc_pkg::QW; k++) begin : g_stage
            localparam int SH = bsc_pkg::QW - 1 - k;
            logic [bsc_pkg::REM_W-1:0] rem_src;
            logic [bsc_pkg::DVS_W-1:0] dvs_src;
            logic [bsc_pkg::QW-1:0]    quo_src;
            bsc_pkg::bsc_side_t        side_src;
            logic [bsc_pkg::REM_W:0]   trial;

            if (k == 0) begin : g_first
                assign rem_src  = in_rem;
                assign dvs_src  = in_dvs;
                assign quo_src  = '0;
                assign side_src = in_side;
            end else begin : g_next
                assign rem_src  = rem_reg[k-1];
                assign dvs_src  = dvs_reg[k-1];
                assign quo_src  = quo_reg[k-1];
                assign side_src = side_reg[k-1];
            end

            // trial subtract of the shifted divisor
            assign trial = {1'b0, rem_src}
                         - {1'b0, (bsc_pkg::REM_W'(dvs_src) << SH)};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= trial[bsc_pkg::REM_W] ? rem_src
                                                         : trial[bsc_pkg::REM_W-1:0];
                    quo_reg[k]  <= {quo_src[bsc_pkg::QW-2:0], ~trial[bsc_pkg::REM_W]};
                    dvs_reg[k]  <= dvs_src;
                    side_reg[k] <= side_src;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[bsc_pkg::QW-1];
    assign out_quo   = quo_reg[bsc_pkg::QW-1];
    assign out_side  = side_reg[bsc_pkg::QW-1];

endmodule

### hw/rtl/barometric_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation of raw sensor readings.
// ----------------------------------------------------------------------------
// pipeline: 13 front stages, 35 divider stages and 5 correction stages from
//   input transfer to m_tvalid; the divider resolves one quotient bit per stage
// throughput: one item per cycle; the whole pipeline holds while a result
//   waits on m_tready
// reset: synchronous active-low aresetn clears valid bits and all coefficients
module barometric_sensor_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temp [19:0], raw_press [39:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // temp_centi [14:0], fine_temp [34:15],
                                   // press_q17_8 [59:35], zero [63:60]
    output logic        m_tuser,   // div_zero [0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // configuration registers
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_last_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (bsc_pkg::reg_idx_t'(cfg_index))
                bsc_pkg::REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                bsc_pkg::REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                bsc_pkg::REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                bsc_pkg::REG_PRESS_LAST:  press_last_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // coefficient slices
    logic        [15:0] t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = $signed(temp_coeffs_reg[31:16]);
    assign t3 = $signed(temp_coeffs_reg[47:32]);
    assign p1 = press_low_reg[15:0];
    assign p2 = $signed(press_low_reg[31:16]);
    assign p3 = $signed(press_low_reg[47:32]);
    assign p4 = $signed(press_low_reg[63:48]);
    assign p5 = $signed(press_high_reg[15:0]);
    assign p6 = $signed(press_high_reg[31:16]);
    assign p7 = $signed(press_high_reg[47:32]);
    assign p8 = $signed(press_high_reg[63:48]);
    assign p9 = $signed(press_last_reg);

    // global advance: the output slot is empty or being taken
    logic en;
    assign en       = ~m_tvalid | m_tready;
    assign s_tready = en;

    // front-end valid bits
    logic [12:0] fv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= '0;
        end else if (en) begin
            fv_reg <= {fv_reg[11:0], s_tvalid};
        end
    end

    // front-end payload
    logic        [19:0] rt_reg;
    logic        [19:0] rp_reg [9];
    logic signed [17:0] ta_reg;
    logic signed [16:0] td_reg;
    logic signed [33:0] pa_reg;
    logic signed [33:0] dsq_reg;
    logic signed [22:0] a_reg;
    logic signed [37:0] bq_reg;
    logic signed [19:0] fine_reg [8];
    logic signed [14:0] tc_reg [7];
    logic signed [20:0] pa2_reg;
    logic signed [41:0] asq_reg;
    logic signed [36:0] ap5_reg, ap2_reg, ap5b_reg, ap2b_reg;
    logic signed [57:0] b1_reg, c1_reg, b_reg;
    logic signed [50:0] aa_reg;
    logic signed [41:0] hi_reg;
    logic        [41:0] lo_reg;
    logic signed [58:0] xn_reg;
    logic signed [34:0] d_reg;
    logic signed [71:0] x_reg;
    logic               neg_reg, dz_reg;
    logic [bsc_pkg::REM_W-1:0] ux_reg, ux2_reg;
    logic [bsc_pkg::DVS_W-1:0] ud_reg, ud2_reg;
    bsc_pkg::bsc_side_t        fside_reg;

    // fine temperature saturation
    logic signed [24:0] fsum;
    logic signed [19:0] fine_next;
    always_comb begin
        fsum = 25'(a_reg) + 25'($signed(bq_reg[37:14]));
        if (fsum < bsc_pkg::FINE_MIN) begin
            fine_next = 20'(bsc_pkg::FINE_MIN);
        end else if (fsum > bsc_pkg::FINE_MAX) begin
            fine_next = 20'(bsc_pkg::FINE_MAX);
        end else begin
            fine_next = fsum[19:0];
        end
    end

    // temperature in hundredths of a degree
    logic signed [23:0] tcw;
    logic signed [15:0] tcs;
    logic signed [14:0] tc_next;
    always_comb begin
        tcw = 24'(fine_reg[0]) * 24'sd5 + 24'sd128;
        tcs = tcw[23:8];
        if (tcs < bsc_pkg::TEMP_MIN) begin
            tc_next = 15'(bsc_pkg::TEMP_MIN);
        end else if (tcs > bsc_pkg::TEMP_MAX) begin
            tc_next = 15'(bsc_pkg::TEMP_MAX);
        end else begin
            tc_next = tcs[14:0];
        end
    end

    // denominator reassembly and numerator offset
    logic signed [67:0] full_prod;
    logic        [20:0] pdiff;
    assign full_prod = (68'(hi_reg) <<< 26) + $signed({26'b0, lo_reg});
    assign pdiff     = 21'h100000 - {1'b0, rp_reg[8]};

    // front-end stages
    always_ff @(posedge aclk) begin
        if (en) begin
            // input capture
            rt_reg    <= s_tdata[19:0];
            rp_reg[0] <= s_tdata[39:20];
            for (int i = 1; i < 9; i++) begin
                rp_reg[i] <= rp_reg[i-1];
            end
            // temperature differences
            ta_reg  <= $signed({1'b0, rt_reg[19:3]}) - $signed({1'b0, t1, 1'b0});
            td_reg  <= $signed({1'b0, rt_reg[19:4]}) - $signed({1'b0, t1});
            // temperature products
            pa_reg  <= ta_reg * t2;
            dsq_reg <= td_reg * td_reg;
            a_reg   <= $signed(pa_reg[33:11]);
            bq_reg  <= $signed({1'b0, dsq_reg[32:12]}) * t3;
            // fine temperature and its carry line
            fine_reg[0] <= fine_next;
            for (int i = 1; i < 8; i++) begin
                fine_reg[i] <= fine_reg[i-1];
            end
            tc_reg[0] <= tc_next;
            for (int i = 1; i < 7; i++) begin
                tc_reg[i] <= tc_reg[i-1];
            end
            pa2_reg <= 21'(fine_reg[0]) - 21'sd128000;
            // pressure polynomial products
            asq_reg  <= pa2_reg * pa2_reg;
            ap5_reg  <= pa2_reg * p5;
            ap2_reg  <= pa2_reg * p2;
            b1_reg   <= asq_reg * p6;
            c1_reg   <= asq_reg * p3;
            ap5b_reg <= ap5_reg;
            ap2b_reg <= ap2_reg;
            // polynomial sums
            b_reg  <= b1_reg + (58'(ap5b_reg) <<< 17) + (58'(p4) <<< 35);
            aa_reg <= 51'sd140737488355328 + 51'($signed(c1_reg[57:8]))
                    + (51'(ap2b_reg) <<< 12);
            // denominator partial products and numerator
            hi_reg <= $signed(aa_reg[50:26]) * $signed({1'b0, p1});
            lo_reg <= 42'(aa_reg[25:0]) * 42'(p1);
            xn_reg <= $signed(59'({pdiff, 31'b0})) - 59'(b_reg);
            // denominator and scaled numerator
            d_reg  <= full_prod[67:33];
            x_reg  <= xn_reg * 13'sd3125;
            // magnitudes and signs
            neg_reg <= x_reg[71] ^ d_reg[34];
            dz_reg  <= (d_reg == '0);
            ux_reg  <= x_reg[71] ? bsc_pkg::REM_W'(-x_reg) : bsc_pkg::REM_W'(x_reg);
            ud_reg  <= d_reg[34] ? bsc_pkg::DVS_W'(-d_reg) : bsc_pkg::DVS_W'(d_reg);
            // quotient overflow check
            ux2_reg        <= ux_reg;
            ud2_reg        <= ud_reg;
            fside_reg.tc   <= tc_reg[6];
            fside_reg.fine <= fine_reg[7];
            fside_reg.dz   <= dz_reg;
            fside_reg.neg  <= neg_reg;
            fside_reg.ovf  <= (ux_reg >= bsc_pkg::REM_W'({ud_reg, 35'b0}));
        end
    end

    // quotient unit
    logic                   dv_valid;
    logic [bsc_pkg::QW-1:0] dv_quo;
    bsc_pkg::bsc_side_t     dv_side;

    bsc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fv_reg[12]),
        .in_rem    (ux2_reg),
        .in_dvs    (ud2_reg),
        .in_side   (fside_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // back-end valid bits
    logic [4:0] bv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bv_reg <= '0;
        end else if (en) begin
            bv_reg <= {bv_reg[3:0], dv_valid};
        end
    end

    // back-end payload
    logic signed [35:0] p_reg, p2_reg, p3_reg;
    logic signed [45:0] sq_reg;
    logic signed [51:0] v2p_reg;
    logic signed [61:0] v1p_reg;
    logic signed [32:0] v2_reg;
    logic signed [38:0] sum_reg;
    bsc_pkg::bsc_side_t bside_reg [4];
    logic [63:0]        out_data_reg;
    logic               out_user_reg;

    // signed, saturated quotient
    logic signed [35:0] p_next;
    always_comb begin
        if (dv_side.ovf) begin
            p_next = dv_side.neg ? 36'sh800000000 : 36'sh7FFFFFFFF;
        end else begin
            p_next = dv_side.neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});
        end
    end

    // final pressure and saturation
    logic signed [31:0] fin;
    logic        [24:0] press_next;
    always_comb begin
        fin = 32'($signed(sum_reg[38:8])) + (32'(p7) <<< 4);
        if (bside_reg[3].dz || fin < 0) begin
            press_next = '0;
        end else if (fin > bsc_pkg::PRESS_MAX) begin
            press_next = 25'(bsc_pkg::PRESS_MAX);
        end else begin
            press_next = fin[24:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg        <= p_next;
            bside_reg[0] <= dv_side;
            for (int i = 1; i < 4; i++) begin
                bside_reg[i] <= bside_reg[i-1];
            end
            // correction products
            sq_reg  <= $signed(p_reg[35:13]) * $signed(p_reg[35:13]);
            v2p_reg <= p_reg * p8;
            p2_reg  <= p_reg;
            v1p_reg <= sq_reg * p9;
            v2_reg  <= $signed(v2p_reg[51:19]);
            p3_reg  <= p2_reg;
            // correction sum
            sum_reg <= 39'(p3_reg) + 39'($signed(v1p_reg[61:25])) + 39'(v2_reg);
            // output register
            out_data_reg <= {4'b0, press_next, bside_reg[3].fine, bside_reg[3].tc};
            out_user_reg <= bside_reg[3].dz;
        end
    end

    assign m_tvalid = bv_reg[4];
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### hw/rtl/bsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_assertions
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [63:0] cfg_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // zero denominator forces pressure to zero
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[59:35] == 25'd0)
        else $error("pressure not zero on zero denominator");

    // temperature stays within sensor range
    a_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[14:0]) >= -15'sd4000
                  && $signed(m_tdata[14:0]) <= 15'sd8500)
        else $error("temperature out of range");

    // no result straight out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind barometric_sensor_compensation bsc_assertions u_bsc_assertions (.*);
